// File: design/uptclk_pkg.sv
// uptclk_pkg: shared constants and types for the uptime clock block
// no dependencies; imported by every module of the block

package uptclk_pkg;

    // payload widths
    localparam int SAMPLE_W  = 16;
    localparam int CYCLE_W   = 64;
    localparam int UPTIME_W  = 64;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CPU_W      = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RELOAD_DIVISOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_BASE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_US  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CALIBRATED     = 2'd3;

    // configuration reset values
    localparam logic [SAMPLE_W-1:0] DIVISOR_RESET = 16'd1193;
    localparam logic [CPU_W-1:0]    CPU_RESET     = 32'd1;

    // counts to microseconds: 1000000 / 1193180 reduced to 50000 / 59659
    localparam int                  CNT_MULT_W  = 16;
    localparam logic [CNT_MULT_W-1:0] CNT_MULT  = 16'd50000;
    localparam logic [CPU_W-1:0]    CNT_DIVISOR = 32'd59659;
    localparam int                  HALF_W      = CYCLE_W / 2;
    localparam int                  PROD_W      = HALF_W + CNT_MULT_W;

    // shared divider
    localparam int DVD_W   = CYCLE_W + CNT_MULT_W;
    localparam int STEP_W  = $clog2(DVD_W + 1);
    localparam logic [STEP_W-1:0] STEPS_CYCLE = STEP_W'(CYCLE_W);
    localparam logic [STEP_W-1:0] STEPS_COUNT = STEP_W'(DVD_W);

    // divider command
    typedef struct packed {
        logic load;
        logic step;
    } t_div_cmd;

endpackage

// File: design/uptclk_in_if.sv
// uptclk_in_if: request channel carrying a countdown sample and a cycle count
// depends on uptclk_pkg

interface uptclk_in_if import uptclk_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] countdown_sample;
    logic [CYCLE_W-1:0]  cycle_now;

    modport source (output valid, output countdown_sample, output cycle_now, input ready);
    modport sink   (input valid, input countdown_sample, input cycle_now, output ready);
endinterface

// File: design/uptclk_out_if.sv
// uptclk_out_if: result channel carrying uptime in microseconds
// depends on uptclk_pkg

interface uptclk_out_if import uptclk_pkg::*;;
    logic                valid;
    logic                ready;
    logic [UPTIME_W-1:0] uptime_us;
    logic                from_cycles;

    modport source (output valid, output uptime_us, output from_cycles, input ready);
    modport sink   (input valid, input uptime_us, input from_cycles, output ready);
endinterface

// File: design/uptclk_divider.sv
// uptclk_divider: shared restoring divider, one quotient bit per cycle while step is set
// depends on uptclk_pkg

module uptclk_divider import uptclk_pkg::*; (
    input  logic                i_clk,
    input  t_div_cmd            i_cmd,
    input  logic [DVD_W-1:0]    i_dividend,
    input  logic [CPU_W-1:0]    i_divisor,
    output logic [UPTIME_W-1:0] o_quotient
);

    logic [DVD_W-1:0] r_quo;
    logic [CPU_W-1:0] r_rem;
    logic [CPU_W-1:0] r_dvs;
    logic [CPU_W:0]   trial;
    logic [CPU_W:0]   diff;
    logic             ge;

    // trial subtract of the divisor from the shifted partial remainder
    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    // load operands or take one quotient bit; a zero divisor yields all ones
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= ge ? diff[CPU_W-1:0] : trial[CPU_W-1:0];
        end
    end

    assign o_quotient = r_quo[UPTIME_W-1:0];

endmodule

// File: design/uptclk_poll.sv
// uptclk_poll: countdown progress tracking and 64-bit count accumulation
// depends on uptclk_pkg

module uptclk_poll import uptclk_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_update,
    input  logic [SAMPLE_W-1:0] i_divisor,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic [CYCLE_W-1:0]  o_counts
);

    logic [SAMPLE_W-1:0] r_prior;
    logic [CYCLE_W-1:0]  r_acc;
    logic [SAMPLE_W-1:0] progress;
    logic [SAMPLE_W-1:0] added;

    // progress within the period, allowing one countdown wrap since last poll
    always_comb begin
        progress = i_divisor - i_sample;
        if (progress >= r_prior) begin
            added = progress - r_prior;
        end else begin
            added = progress + i_divisor - r_prior;
        end
    end

    // accumulate counts and remember this poll's progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior <= '0;
            r_acc   <= '0;
        end else if (i_update) begin
            r_prior <= progress;
            r_acc   <= r_acc + {{(CYCLE_W-SAMPLE_W){1'b0}}, added};
        end
    end

    assign o_counts = r_acc;

endmodule

// File: design/uptime_clock_from_countdown_and_tsc.sv
// uptime_clock_from_countdown_and_tsc: top level with config registers and sequencer
// depends on uptclk_pkg, uptclk_in_if, uptclk_out_if, uptclk_divider, uptclk_poll

// Answers one uptime query at a time in microseconds. When calibrated is set the
// result is (cycle_now - cycle_base) / cycles_per_us, a zero cycles_per_us giving
// all ones; otherwise the countdown progress since the last query is added to a
// 64-bit count that is converted at 1193180 counts per second. The shared divider
// is loaded as the request is taken on the cycle counter path, or after the low
// multiply state with an 80-bit dividend on the countdown path. It retires one
// quotient bit per cycle; the result is registered when it is done and no earlier
// result waits to be taken. The request side is then ready again, so the next query
// may start while the previous result waits. The user must write configuration
// only while no query is in flight; the block itself does not enforce this.

module uptime_clock_from_countdown_and_tsc import uptclk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    uptclk_in_if.sink             i_req,
    uptclk_out_if.source          o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MUL_LO = 2'd1;
    localparam logic [1:0] ST_MUL_HI = 2'd2;
    localparam logic [1:0] ST_DIV    = 2'd3;

    logic [SAMPLE_W-1:0] r_reload;
    logic [CYCLE_W-1:0]  r_base;
    logic [CPU_W-1:0]    r_cpu;
    logic                r_cal;

    logic [1:0]          r_state;
    logic [STEP_W-1:0]   r_steps;
    logic                r_from;
    logic [PROD_W-1:0]   r_prod_lo;
    logic                r_ovalid;
    logic [UPTIME_W-1:0] r_uptime;
    logic                r_ofrom;

    logic                req_fire;
    logic                finish;
    logic [CYCLE_W-1:0]  counts;
    logic [HALF_W-1:0]   mul_a;
    logic [PROD_W-1:0]   mul_p;
    t_div_cmd            div_cmd;
    logic [DVD_W-1:0]    dividend;
    logic [CPU_W-1:0]    divisor;
    logic [UPTIME_W-1:0] quotient;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= DIVISOR_RESET;
            r_base   <= '0;
            r_cpu    <= CPU_RESET;
            r_cal    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RELOAD_DIVISOR: r_reload <= i_cfg_data[SAMPLE_W-1:0];
                REG_CYCLE_BASE:     r_base   <= i_cfg_data;
                REG_CYCLES_PER_US:  r_cpu    <= i_cfg_data[CPU_W-1:0];
                REG_CALIBRATED:     r_cal    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign finish      = (r_state == ST_DIV) && (r_steps == '0) && (!r_ovalid || o_rsp.ready);

    // countdown state
    uptclk_poll u_poll (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (req_fire && !r_cal),
        .i_divisor(r_reload),
        .i_sample (i_req.countdown_sample),
        .o_counts (counts)
    );

    // one 32x16 multiplier used on the low then the high half of the count
    assign mul_a = (r_state == ST_MUL_HI) ? counts[CYCLE_W-1:HALF_W] : counts[HALF_W-1:0];
    assign mul_p = {{CNT_MULT_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, CNT_MULT};

    // divider operands and command
    always_comb begin
        div_cmd.load = 1'b0;
        div_cmd.step = (r_state == ST_DIV) && (r_steps != '0);
        dividend     = {i_req.cycle_now - r_base, {CNT_MULT_W{1'b0}}};
        divisor      = r_cpu;
        if (r_state == ST_MUL_HI) begin
            div_cmd.load = 1'b1;
            dividend     = {{(DVD_W-PROD_W){1'b0}}, r_prod_lo} + {mul_p, {HALF_W{1'b0}}};
            divisor      = CNT_DIVISOR;
        end else if (req_fire && r_cal) begin
            div_cmd.load = 1'b1;
        end
    end

    uptclk_divider u_div (
        .i_clk     (i_clk),
        .i_cmd     (div_cmd),
        .i_dividend(dividend),
        .i_divisor (divisor),
        .o_quotient(quotient)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_steps <= '0;
            r_from  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (req_fire) begin
                        r_from <= r_cal;
                        if (r_cal) begin
                            r_steps <= STEPS_CYCLE;
                            r_state <= ST_DIV;
                        end else begin
                            r_state <= ST_MUL_LO;
                        end
                    end
                end
                ST_MUL_LO: begin
                    r_state <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    r_steps <= STEPS_COUNT;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_steps != '0) begin
                        r_steps <= r_steps - 1'b1;
                    end else if (finish) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // low partial product
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL_LO) begin
            r_prod_lo <= mul_p;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (finish) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_uptime <= quotient;
            r_ofrom  <= r_from;
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.uptime_us   = r_uptime;
    assign o_rsp.from_cycles = r_ofrom;

endmodule

// File: design/uptclk_checker.sv
// uptclk_checker: port-level assertions for the uptime clock block
// depends on uptclk_pkg; bound to uptime_clock_from_countdown_and_tsc

module uptclk_checker import uptclk_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [UPTIME_W-1:0] i_rsp_uptime,
    input logic                i_rsp_from
);

    // request side busy right after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request side ready right after a request");

    // a result never appears in the cycle after a request
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !$rose(i_rsp_valid))
        else $error("result appeared one cycle after request");

    // a new result comes with the request side free again
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> i_req_ready)
        else $error("result raised while still busy");

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_uptime) && $stable(i_rsp_from)))
        else $error("stalled result changed");

endmodule

bind uptime_clock_from_countdown_and_tsc uptclk_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_uptime(o_rsp.uptime_us),
    .i_rsp_from  (o_rsp.from_cycles)
);
